// File: design/srh_pkg.sv
// ----------------------------------------------------------------------------
// srh_pkg: shared types and constants
// Word layout between the front and back parts of the residual histogram.
// ----------------------------------------------------------------------------
package srh_pkg;

	localparam int IDX_W   = 16;
	localparam int CNT_W   = 32;
	localparam int SIZE_W  = 17;
	localparam int SHIFT_W = 4;

	typedef enum logic {
		OP_ACC  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] code;
		logic [CNT_W-1:0] total;
		logic             oor;
	} job_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} qstat_t;

endpackage

// File: design/stereo_residual_histogram.sv
// ----------------------------------------------------------------------------
// stereo_residual_histogram: residual histogram of interleaved stereo audio
// Top level: front classifier, two-entry queue, histogram back end.
// ----------------------------------------------------------------------------
// After reset the block clears its NUM_BINS-entry histogram memory, one entry
// per cycle, and holds busy high until the clear is done; configuration
// writes are taken throughout. A word is accepted when start is high and busy
// is low. With the back end idle, the word is written into the queue, then
// popped into the result register as the back end enters write-back, where
// done is high for a single cycle; the receiver cannot stall, so the result
// must be taken in that one cycle. The back end reads one memory bin per word,
// writes it back in write-back for an in-range sample word and takes no new
// word until idle; the two-entry queue absorbs bursts, busy rising while full.
module stereo_residual_histogram import srh_pkg::*; #(
	parameter int NUM_BINS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SHIFT_W-1:0] cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic signed [15:0] sample,
	input  logic [IDX_W-1:0]   bin_index,
	output logic               done,
	output logic [IDX_W-1:0]   residual_code,
	output logic [CNT_W-1:0]   bin_count,
	output logic [CNT_W-1:0]   total_samples,
	output logic               out_of_range
);

	qstat_t q_stat;
	job_t   push_job;
	job_t   head;
	logic   push;
	logic   pop;
	logic   clearing;

	srh_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.opcode   (opcode),
		.sample   (sample),
		.bin_index(bin_index),
		.clearing (clearing),
		.q_stat   (q_stat),
		.busy     (busy),
		.push     (push),
		.push_job (push_job)
	);

	srh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	srh_back #(
		.NUM_BINS(NUM_BINS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.clearing     (clearing),
		.done         (done),
		.residual_code(residual_code),
		.bin_count    (bin_count),
		.total_samples(total_samples),
		.out_of_range (out_of_range)
	);

endmodule

// File: design/srh_ram.sv
// ----------------------------------------------------------------------------
// srh_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/srh_queue.sv
// ----------------------------------------------------------------------------
// srh_queue: two-entry word queue
// Decouples the classifying front part from the histogram back part.
// ----------------------------------------------------------------------------
module srh_queue import srh_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	input  logic   pop,
	output job_t   head,
	output qstat_t stat
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.not_empty = (cnt_q != 2'd0);
	assign stat.full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.not_empty)
		else $error("queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue pushed while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of bounds");

endmodule

// File: design/srh_front.sv
// ----------------------------------------------------------------------------
// srh_front: accept and classify words
// Quantizes, predicts per channel and zigzag-maps each sample word, and range-checks every word.
// ----------------------------------------------------------------------------
module srh_front import srh_pkg::*; #(
	parameter int NUM_BINS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [SHIFT_W-1:0]  cfg_wdata,
	input  logic                start,
	input  logic                opcode,
	input  logic signed [15:0]  sample,
	input  logic [IDX_W-1:0]    bin_index,
	input  logic                clearing,
	input  qstat_t              q_stat,
	output logic                busy,
	output logic                push,
	output job_t                push_job
);

	logic [SHIFT_W-1:0] quant_shift_q;
	logic [15:0]        prev_left_q;
	logic [15:0]        prev_right_q;
	logic               chan_q;
	logic [CNT_W-1:0]   total_q;

	logic signed [15:0] q_val;
	logic [15:0]        prev;
	logic [15:0]        diff;
	logic [IDX_W-1:0]   code;
	logic [SIZE_W-1:0]  size;
	logic [CNT_W-1:0]   total_nxt;
	logic               is_read;

	assign busy    = clearing || q_stat.full;
	assign push    = start && !busy;
	assign is_read = (op_t'(opcode) == OP_READ);

	always_comb begin
		q_val     = sample >>> quant_shift_q;
		prev      = chan_q ? prev_right_q : prev_left_q;
		diff      = 16'(q_val) - prev;
		code      = diff[15] ? {~diff[14:0], 1'b1} : {diff[14:0], 1'b0};
		size      = SIZE_W'(NUM_BINS) >> quant_shift_q;
		total_nxt = (total_q == '1) ? total_q : total_q + CNT_W'(1);

		push_job.op = op_t'(opcode);
		if (is_read) begin
			push_job.addr  = bin_index;
			push_job.code  = '0;
			push_job.total = total_q;
			push_job.oor   = ({1'b0, bin_index} >= size);
		end else begin
			push_job.addr  = code;
			push_job.code  = code;
			push_job.total = total_nxt;
			push_job.oor   = ({1'b0, code} >= size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_shift_q <= '0;
			prev_left_q   <= '0;
			prev_right_q  <= '0;
			chan_q        <= 1'b0;
			total_q       <= '0;
		end else begin
			if (cfg_we) begin
				quant_shift_q <= cfg_wdata;
			end
			if (push && !is_read) begin
				if (chan_q) begin
					prev_right_q <= 16'(q_val);
				end else begin
					prev_left_q <= 16'(q_val);
				end
				chan_q  <= ~chan_q;
				total_q <= total_nxt;
			end
		end
	end

endmodule

// File: design/srh_back.sv
// ----------------------------------------------------------------------------
// srh_back: histogram store and result stage
// Clears the store after reset, then reads one bin per word, writing it back for in-range sample words.
// ----------------------------------------------------------------------------
module srh_back import srh_pkg::*; #(
	parameter int NUM_BINS = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  qstat_t           q_stat,
	input  job_t             head,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [IDX_W-1:0] residual_code,
	output logic [CNT_W-1:0] bin_count,
	output logic [CNT_W-1:0] total_samples,
	output logic             out_of_range
);

	localparam int AW = $clog2(NUM_BINS);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_WB    = 3'b100
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_addr_q;
	job_t             cur_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [CNT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] sat_cnt;
	logic             is_upd;

	srh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head.addr[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && q_stat.not_empty;
	assign sat_cnt  = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
	assign is_upd   = (cur_q.op == OP_ACC) && !cur_q.oor;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q.addr[AW-1:0];
		ram_wdata = sat_cnt;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_WB: begin
				ram_we = is_upd;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign done          = (state_q == ST_WB);
	assign residual_code = cur_q.code;
	assign total_samples = cur_q.total;
	assign out_of_range  = cur_q.oor;
	assign bin_count     = cur_q.oor ? '0 : ((cur_q.op == OP_ACC) ? sat_cnt : ram_rdata);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_stat.not_empty) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_write_when: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || (state_q == ST_WB && is_upd)))
		else $error("histogram written outside clear or update");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!pop && !done))
		else $error("word processed during clearing pass");

endmodule

// File: tb/stereo_residual_histogram_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_residual_histogram_tb: self-checking testbench
// A queue-fed driver presents sample and bin-read words with random gaps; a
// monitor predicts each result at acceptance (quantize, predict, zigzag, bin
// update) and compares every done strobe against the oldest prediction.
// Phases at several quantization shifts, 0 and 15 among them, one without gaps.
// ----------------------------------------------------------------------------
module stereo_residual_histogram_tb;
	import srh_pkg::*;

	localparam int NUM_BINS  = 65536;
	localparam int LIMIT     = 400000;
	localparam int DRAIN_CYC = 6;

	typedef struct {
		op_t              op;
		logic [15:0]      smp;
		logic [IDX_W-1:0] idx;
	} hist_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] code;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] total;
		logic             oor;
	} hist_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [SHIFT_W-1:0]   cfg_wdata = '0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 opcode = 1'b0;
	logic signed [15:0]   sample = '0;
	logic [IDX_W-1:0]     bin_index = '0;
	logic                 done;
	logic [IDX_W-1:0]     residual_code;
	logic [CNT_W-1:0]     bin_count;
	logic [CNT_W-1:0]     total_samples;
	logic                 out_of_range;

	stereo_residual_histogram #(.NUM_BINS(NUM_BINS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.sample        (sample),
		.bin_index     (bin_index),
		.done          (done),
		.residual_code (residual_code),
		.bin_count     (bin_count),
		.total_samples (total_samples),
		.out_of_range  (out_of_range)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	hist_cmd_t    pending_cmds[$];
	hist_result_t expected_words[$];

	// predictor state
	logic [SHIFT_W-1:0] model_shift = '0;
	logic [15:0]        model_prev_l = '0;
	logic [15:0]        model_prev_r = '0;
	logic               model_chan = 1'b0;
	logic [31:0]        model_total = '0;
	bit   [31:0]        model_hist [NUM_BINS];

	int  errors = 0;
	int  cycles = 0;
	int  sent_cnt = 0;
	int  accept_cnt = 0;
	int  n_acc = 0;
	int  n_read = 0;
	int  n_oor = 0;
	int  n_checked = 0;
	bit  no_gaps = 1'b0;

	// stimulus-side tracking
	logic [SHIFT_W-1:0] gen_shift = '0;
	int                 gen_chan = 0;
	int                 walk[2] = '{0, 0};

	function automatic hist_result_t hist_predict(op_t op, logic [15:0] smp,
	                                               logic [IDX_W-1:0] idx);
		logic [15:0]  q;
		logic [15:0]  diff;
		logic [16:0]  size;
		hist_result_t r;
		size = 17'(NUM_BINS) >> model_shift;
		r = '0;
		if (op == OP_ACC) begin
			q = $signed(smp) >>> model_shift;
			diff = q - (model_chan ? model_prev_r : model_prev_l);
			r.code = diff[15] ? {~diff[14:0], 1'b1} : {diff[14:0], 1'b0};
			if ({1'b0, r.code} < size) begin
				if (model_hist[r.code] != 32'hFFFF_FFFF)
					model_hist[r.code]++;
				r.count = model_hist[r.code];
			end else begin
				r.oor = 1'b1;
			end
			if (model_chan)
				model_prev_r = q;
			else
				model_prev_l = q;
			model_chan = ~model_chan;
			if (model_total != 32'hFFFF_FFFF)
				model_total++;
		end else if ({1'b0, idx} < size) begin
			r.count = model_hist[idx];
		end else begin
			r.oor = 1'b1;
		end
		r.total = model_total;
		return r;
	endfunction

	// driver: hold the word until taken, then advance or idle
	always @(negedge clk) begin
		hist_cmd_t c;
		if (!start || accept_cnt == sent_cnt) begin
			if (pending_cmds.size() != 0 &&
			    (no_gaps || $urandom_range(0, 99) >= 17)) begin
				c = pending_cmds.pop_front();
				start     <= 1'b1;
				opcode    <= c.op;
				sample    <= c.smp;
				bin_index <= c.idx;
				sent_cnt  <= sent_cnt + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict accepted words
	always @(posedge clk) begin
		hist_result_t e;
		cycles++;
		if (arst_n) begin
			if (cfg_we)
				model_shift = cfg_wdata;
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result with no word outstanding: code %0d count %0d",
					       residual_code, bin_count);
					errors++;
				end else begin
					e = expected_words.pop_front();
					n_checked++;
					if (out_of_range)
						n_oor++;
					if (residual_code !== e.code) begin
						$error("residual_code: expected %0d, got %0d", e.code, residual_code);
						errors++;
					end
					if (bin_count !== e.count) begin
						$error("bin_count: expected %0d, got %0d", e.count, bin_count);
						errors++;
					end
					if (total_samples !== e.total) begin
						$error("total_samples: expected %0d, got %0d", e.total, total_samples);
						errors++;
					end
					if (out_of_range !== e.oor) begin
						$error("out_of_range: expected %0d, got %0d", e.oor, out_of_range);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				expected_words.push_back(hist_predict(op_t'(opcode), sample, bin_index));
				accept_cnt++;
				if (opcode == OP_ACC)
					n_acc++;
				else
					n_read++;
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_acc(input logic [15:0] smp);
		hist_cmd_t c;
		c.op  = OP_ACC;
		c.smp = smp;
		c.idx = IDX_W'($urandom);
		pending_cmds.push_back(c);
		gen_chan ^= 1;
	endtask

	task automatic push_read(input logic [IDX_W-1:0] idx);
		hist_cmd_t c;
		c.op  = OP_READ;
		c.smp = 16'($urandom);
		c.idx = idx;
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || start || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_shift(input logic [SHIFT_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		gen_shift = v;
	endtask

	// mostly smooth per-channel walks, plus raw samples and bin reads
	task automatic run_phase(input int n_items, input int step);
		int k;
		int sel;
		int b;
		int size;
		for (k = 0; k < n_items; k++) begin
			sel = $urandom_range(0, 99);
			size = NUM_BINS >> gen_shift;
			if (sel < 65) begin
				walk[gen_chan] += $urandom_range(0, 2 * step) - step;
				if (walk[gen_chan] > 32767)
					walk[gen_chan] = 32767;
				if (walk[gen_chan] < -32768)
					walk[gen_chan] = -32768;
				push_acc(16'(walk[gen_chan]));
			end else if (sel < 75) begin
				push_acc(16'($urandom));
			end else begin
				sel = $urandom_range(0, 3);
				if (sel < 2) begin
					push_read(IDX_W'($urandom_range(0, 63)));
				end else if (sel == 2) begin
					b = size - 2 + $urandom_range(0, 3);
					if (b > 65535)
						b -= 2;
					push_read(IDX_W'(b));
				end else begin
					push_read(IDX_W'($urandom));
				end
			end
		end
	endtask

	int shift_plan[10] = '{0, 15, 4, 1, 8, 0, 12, 2, 15, 6};
	int p;

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// full-scale swings, wrap of the difference, reads at both ends
		set_shift(4'd0);
		push_acc(16'sd0);
		push_acc(16'sd0);
		push_acc(16'sd32767);
		push_acc(-16'sd32768);
		push_acc(-16'sd1);
		push_acc(16'sd32767);
		push_read(16'd0);
		push_read(16'd1);
		push_read(16'hFFFE);
		push_read(16'hFFFF);

		// two-bin table: codes past it flagged, not counted
		set_shift(4'd15);
		push_acc(16'sd32767);
		push_acc(-16'sd32768);
		push_acc(16'sd0);
		push_read(16'd0);
		push_read(16'd1);
		push_read(16'd2);
		push_read(16'hFFFF);

		// half table; previous values kept across the shift change
		set_shift(4'd1);
		push_acc(16'sd32767);
		push_acc(-16'sd32768);
		push_acc(-16'sd32768);
		push_read(16'd32767);
		push_read(16'd32768);

		for (p = 0; p < 10; p++) begin
			set_shift(4'(shift_plan[p]));
			if (p == 5)
				no_gaps = 1'b1;
			run_phase(128, $urandom_range(1, 4096));
			if (p == 5) begin
				drain();
				no_gaps = 1'b0;
			end
		end

		drain();
		$display("covered %0d sample words and %0d bin reads over shifts 0 to 15;",
		         n_acc, n_read);
		$display("%0d results checked, %0d flagged out of range", n_checked, n_oor);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
